### design/aou_pkg.sv
// Shared types, constants and register codes for the Adam optimizer update block.
// Depends on nothing; aou_moment and adam_optimizer_update import it.
package aou_pkg;

  localparam int MAX_ELEMENTS_DEF = 4096;

  localparam int IDX_W  = 12;
  localparam int LR_W   = 24;
  localparam int BETA_W = 16;
  localparam int EPS_W  = 24;
  localparam int CFG_W  = 24;
  localparam int CFG_IDX_W = 2;

  localparam logic [LR_W-1:0]   LR_RESET  = 24'd16777;
  localparam logic [BETA_W-1:0] B1_RESET  = 16'd58982;
  localparam logic [BETA_W-1:0] B2_RESET  = 16'd65470;
  localparam logic [EPS_W-1:0]  EPS_RESET = 24'd1;

  localparam logic [31:0] ONE_Q31   = 32'h8000_0000;
  localparam logic [47:0] MASK48    = 48'hFFFF_FFFF_FFFF;
  localparam logic [33:0] STEP_CAP  = 34'h2_0000_0000;
  localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LR  = 2'd0,
    REG_B1  = 2'd1,
    REG_B2  = 2'd2,
    REG_EPS = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [IDX_W-1:0]   element_index;
    logic               new_pass;
    logic signed [31:0] weight_in;
    logic signed [31:0] gradient;
  } in_t;

  typedef struct packed {
    logic signed [31:0] weight_out;
    logic               saturated;
  } out_t;

  // Updated moments of one element, with what the rest of the pipeline needs.
  typedef struct packed {
    logic               valid;
    logic signed [31:0] m;
    logic [47:0]        v;
    logic signed [31:0] w;
    logic [31:0]        d1;
    logic [31:0]        d2;
  } mom_t;

endpackage

### design/aou_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module aou_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/aou_div.sv
// Pipelined restoring divider, one quotient bit per stage, with a side tag.
// No dependencies; a quotient that does not fit is reported through over.
module aou_div #(
  parameter int NUM_W = 79,
  parameter int DEN_W = 32,
  parameter int Q_W   = 64,
  parameter int TAG_W = 1,
  localparam int UP_W = NUM_W - Q_W,
  localparam int CW   = (UP_W > DEN_W) ? UP_W : DEN_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag,
  output logic             out_valid,
  output logic [Q_W-1:0]   quot,
  output logic             over,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld [Q_W+1];
  logic [DEN_W-1:0] rem [Q_W+1];
  logic [Q_W-1:0]   nq  [Q_W+1];
  logic [DEN_W-1:0] dv  [Q_W+1];
  logic             ov  [Q_W+1];
  logic [TAG_W-1:0] tg  [Q_W+1];

  logic [UP_W-1:0] up;
  logic            ov0;

  // The upper part of the numerator must stay below the divisor, otherwise
  // the quotient does not fit.
  assign up  = num[NUM_W-1:Q_W];
  assign ov0 = CW'(up) >= CW'(den);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= ov0 ? '0 : DEN_W'(up);
      nq[0]  <= num[Q_W-1:0];
      dv[0]  <= den;
      ov[0]  <= ov0;
      tg[0]  <= tag;
    end
  end

  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [DEN_W:0] t;
    logic           ge;
    logic [DEN_W:0] diff;

    assign t    = {rem[k-1], nq[k-1][Q_W-1]};
    assign ge   = t >= {1'b0, dv[k-1]};
    assign diff = t - {1'b0, dv[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[DEN_W-1:0] : t[DEN_W-1:0];
        nq[k]  <= {nq[k-1][Q_W-2:0], ge};
        dv[k]  <= dv[k-1];
        ov[k]  <= ov[k-1];
        tg[k]  <= tg[k-1];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign quot      = nq[Q_W];
  assign over      = ov[Q_W];
  assign out_tag   = tg[Q_W];

endmodule

### design/aou_sqrt.sv
// Pipelined integer square root of a 64-bit value, one root bit per stage.
// No dependencies; a side tag travels with each value.
module aou_sqrt #(
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [63:0]      x,
  input  logic [TAG_W-1:0] tag,
  output logic             out_valid,
  output logic [31:0]      root,
  output logic [TAG_W-1:0] out_tag
);

  logic             vld [33];
  logic [33:0]      rem [33];
  logic [31:0]      rt  [33];
  logic [63:0]      xs  [33];
  logic [TAG_W-1:0] tg  [33];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= '0;
      rt[0]  <= '0;
      xs[0]  <= x;
      tg[0]  <= tag;
    end
  end

  for (genvar k = 1; k <= 32; k++) begin : g_step
    logic [35:0] t;
    logic [35:0] tst;
    logic        ge;
    logic [35:0] diff;

    assign t    = {rem[k-1], xs[k-1][63:62]};
    assign tst  = {2'b00, rt[k-1], 2'b01};
    assign ge   = t >= tst;
    assign diff = t - tst;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (en) begin
        vld[k] <= vld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= ge ? diff[33:0] : t[33:0];
        rt[k]  <= {rt[k-1][30:0], ge};
        xs[k]  <= {xs[k-1][61:0], 2'b00};
        tg[k]  <= tg[k-1];
      end
    end
  end

  assign out_valid = vld[32];
  assign root      = rt[32];
  assign out_tag   = tg[32];

endmodule

### design/aou_moment.sv
// Moment update front end: beta powers, moment stores with forwarding, new moments.
// Depends on aou_pkg and aou_ram.
module aou_moment #(
  parameter int MAX_ELEMENTS = aou_pkg::MAX_ELEMENTS_DEF,
  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       accept,
  input  aou_pkg::in_t               item,
  input  logic [aou_pkg::BETA_W-1:0] beta_first,
  input  logic [aou_pkg::BETA_W-1:0] beta_second,
  input  logic                       clearing,
  input  logic [AW-1:0]              clr_addr,
  output aou_pkg::mom_t              mom
);
  import aou_pkg::*;

  logic [31:0] p1, p2, p1_next, p2_next;
  logic [47:0] p1_prod, p2_prod;

  assign p1_prod = 48'(p1) * 48'(beta_first);
  assign p2_prod = 48'(p2) * 48'(beta_second);
  assign p1_next = (accept && item.new_pass) ? p1_prod[47:16] : p1;
  assign p2_next = (accept && item.new_pass) ? p2_prod[47:16] : p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= ONE_Q31;
      p2 <= ONE_Q31;
    end else begin
      p1 <= p1_next;
      p2 <= p2_next;
    end
  end

  logic        in_inr;
  logic [31:0] gmag;
  logic [63:0] gsq;

  assign in_inr = 32'(item.element_index) < 32'(MAX_ELEMENTS);
  assign gmag   = item.gradient[31] ? (~$unsigned(item.gradient) + 32'd1)
                                    : $unsigned(item.gradient);
  assign gsq    = 64'(gmag) * 64'(gmag);

  // Stage A: the accepted item, its squared gradient and bias denominators.
  logic               a_valid;
  logic [IDX_W-1:0]   a_idx;
  logic               a_inr;
  logic signed [31:0] a_w;
  logic signed [31:0] a_g;
  logic [47:0]        a_g2;
  logic [31:0]        a_d1, a_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_idx <= item.element_index;
      a_inr <= in_inr;
      a_w   <= item.weight_in;
      a_g   <= item.gradient;
      a_g2  <= (gsq > 64'(MASK48)) ? MASK48 : gsq[47:0];
      a_d1  <= ONE_Q31 - p1_next;
      a_d2  <= ONE_Q31 - p2_next;
    end
  end

  logic signed [31:0] m_rd;
  logic [47:0]        v_rd;
  logic               wr;
  logic [AW-1:0]      waddr;
  logic signed [31:0] m_new;
  logic [47:0]        v_new;

  assign wr    = clearing || (en && a_valid && a_inr);
  assign waddr = clearing ? clr_addr : AW'(a_idx);

  aou_ram #(.WIDTH(32), .DEPTH(MAX_ELEMENTS)) u_m_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (waddr),
    .wdata (clearing ? 32'd0 : $unsigned(m_new)),
    .re    (accept),
    .raddr (AW'(item.element_index)),
    .rdata (m_rd)
  );

  aou_ram #(.WIDTH(48), .DEPTH(MAX_ELEMENTS)) u_v_ram (
    .clk   (clk),
    .we    (wr),
    .waddr (waddr),
    .wdata (clearing ? 48'd0 : v_new),
    .re    (accept),
    .raddr (AW'(item.element_index)),
    .rdata (v_rd)
  );

  // The element written by the item just ahead is not yet visible in the read data.
  logic               c_inr;
  logic [IDX_W-1:0]   c_idx;
  logic               fwd;
  logic signed [31:0] m_old;
  logic [47:0]        v_old;
  logic [16:0]        b1c, b2c;
  logic signed [49:0] m_acc;
  logic [64:0]        v_acc;

  assign fwd   = mom.valid && c_inr && (c_idx == a_idx);
  assign m_old = !a_inr ? 32'sd0 : (fwd ? mom.m : m_rd);
  assign v_old = !a_inr ? 48'd0  : (fwd ? mom.v : v_rd);
  assign b1c   = 17'h1_0000 - 17'(beta_first);
  assign b2c   = 17'h1_0000 - 17'(beta_second);
  assign m_acc = $signed({2'b00, beta_first}) * m_old + $signed({1'b0, b1c}) * a_g;
  assign v_acc = 65'(beta_second) * 65'(v_old) + 65'(b2c) * 65'(a_g2);
  assign m_new = m_acc[47:16];
  assign v_new = v_acc[63:16];

  always_ff @(posedge clk) begin
    if (rst) begin
      mom.valid <= 1'b0;
    end else if (en) begin
      mom.valid <= a_valid;
    end
    if (en) begin
      mom.m  <= m_new;
      mom.v  <= v_new;
      mom.w  <= a_w;
      mom.d1 <= a_d1;
      mom.d2 <= a_d2;
      c_idx  <= a_idx;
      c_inr  <= a_inr;
    end
  end

endmodule

### design/adam_optimizer_update.sv
// Top level of the fixed-point Adam optimizer weight update pipeline.
// Depends on aou_pkg, aou_moment, aou_div and aou_sqrt.
//
//   channel   | direction | signals                          | transaction
//   ----------+-----------+----------------------------------+--------------------------
//   input     | in        | in_valid, in_stall, in_data      | index, pass, weight, grad
//   output    | out       | out_valid, out_stall, out_data   | updated weight, flag
//   config    | in        | cfg_write, cfg_index, cfg_data   | one register write
//
// One transaction enters per cycle and one result leaves per cycle while neither
// in_stall nor out_stall holds the flow. The accepting edge loads the first
// of two moment stages; after it come the second moment stage, the 65-stage bias
// correction dividers, the 33-stage square root, two multiply stages, the 35-stage
// step divider and the output register.
// After reset the moment memories are swept to zero at one entry per cycle, covering
// all MAX_ELEMENTS entries; in_stall is high during the sweep.
// A two-entry output buffer lets the pipeline keep taking transactions while one
// result waits; the whole pipeline freezes only when both entries are occupied.
module adam_optimizer_update #(
  parameter int MAX_ELEMENTS = aou_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  aou_pkg::in_t                  in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output aou_pkg::out_t                 out_data,
  input  logic                          cfg_write,
  input  logic [aou_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aou_pkg::CFG_W-1:0]     cfg_data
);
  import aou_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;

  // Configuration registers. Writes must arrive only while the pipeline is empty (the block
  // does not enforce it), so the stages read them directly.
  logic [LR_W-1:0]   step_size;
  logic [BETA_W-1:0] beta_first;
  logic [BETA_W-1:0] beta_second;
  logic [EPS_W-1:0]  epsilon_term;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size     <= LR_RESET;
      beta_first    <= B1_RESET;
      beta_second   <= B2_RESET;
      epsilon_term  <= EPS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LR:  step_size     <= cfg_data[LR_W-1:0];
        REG_B1:  beta_first    <= cfg_data[BETA_W-1:0];
        REG_B2:  beta_second   <= cfg_data[BETA_W-1:0];
        REG_EPS: epsilon_term  <= cfg_data[EPS_W-1:0];
        default: ;
      endcase
    end
  end

  // Clearing sweep of the moment memories after reset.
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == AW'(MAX_ELEMENTS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Every stage advances together; only a full output buffer holds them.
  logic skid_valid;
  logic en;
  logic accept;

  assign en       = !skid_valid;
  assign in_stall = clearing || skid_valid;
  assign accept   = in_valid && !in_stall;

  mom_t mom;

  aou_moment #(.MAX_ELEMENTS(MAX_ELEMENTS)) u_moment (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .accept      (accept),
    .item        (in_data),
    .beta_first  (beta_first),
    .beta_second (beta_second),
    .clearing    (clearing),
    .clr_addr    (clr_addr),
    .mom         (mom)
  );

  // Bias correction. The first moment goes in as a magnitude and its sign rides along
  // with the weight in the tag; a zero denominator is flagged for the final stage.
  logic [31:0] mag;
  logic        dzero_in;
  logic [33:0] mtag_in, mtag_out;
  logic [63:0] mhat;
  logic [63:0] vq;
  logic        v_over;
  logic        v_valid;
  logic        dzero;

  assign mag      = mom.m[31] ? (~$unsigned(mom.m) + 32'd1) : $unsigned(mom.m);
  assign dzero_in = (mom.d1 == 32'd0) || (mom.d2 == 32'd0);
  assign mtag_in  = {mom.m[31], (mom.m == 32'sd0), mom.w};

  aou_div #(.NUM_W(65), .DEN_W(32), .Q_W(64), .TAG_W(34)) u_mhat_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mom.valid),
    .num       (65'(mag) << 31),
    .den       (mom.d1),
    .tag       (mtag_in),
    .out_valid (),
    .quot      (mhat),
    .over      (),
    .out_tag   (mtag_out)
  );

  aou_div #(.NUM_W(79), .DEN_W(32), .Q_W(64), .TAG_W(1)) u_vhat_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (mom.valid),
    .num       (79'(mom.v) << 31),
    .den       (mom.d2),
    .tag       (dzero_in),
    .out_valid (v_valid),
    .quot      (vq),
    .over      (v_over),
    .out_tag   (dzero)
  );

  // Square root of the corrected second moment; mhat and the flags wait alongside.
  logic [98:0] stag_out;
  logic [31:0] sroot;
  logic        s_valid;

  aou_sqrt #(.TAG_W(99)) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v_valid),
    .x         (v_over ? 64'hFFFF_FFFF_FFFF_FFFF : vq),
    .tag       ({mhat, mtag_out, dzero}),
    .out_valid (s_valid),
    .root      (sroot),
    .out_tag   (stag_out)
  );

  // First multiply stage: the denominator and the two halves of lr * mhat.
  logic               m1_valid;
  logic [32:0]        m1_den;
  logic [55:0]        m1_p0, m1_p1;
  logic [34:0]        m1_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m1_valid <= 1'b0;
    end else if (en) begin
      m1_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_den <= 33'(sroot) + 33'(epsilon_term);
      m1_p0  <= 56'(step_size) * 56'(stag_out[66:35]);
      m1_p1  <= 56'(step_size) * 56'(stag_out[98:67]);
      m1_tag <= stag_out[34:0];
    end
  end

  // Second stage: combine the partial products and finish the zero-divisor flag.
  logic        m2_valid;
  logic [87:0] m2_num;
  logic [40:0] m2_den;
  logic [34:0] m2_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_valid <= 1'b0;
    end else if (en) begin
      m2_valid <= m1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_num <= 88'(m1_p0) + (88'(m1_p1) << 32);
      m2_den <= {m1_den, 8'b0};
      m2_tag <= {m1_tag[34:1], m1_tag[0] || (m1_den == 33'd0)};
    end
  end

  // Step division. Any quotient at or above 2^34 is capped anyway, so only 34
  // quotient bits are formed.
  logic        sd_valid;
  logic [33:0] sq;
  logic        s_over;
  logic [34:0] sd_tag;

  aou_div #(.NUM_W(88), .DEN_W(41), .Q_W(34), .TAG_W(35)) u_step_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (m2_valid),
    .num       (m2_num),
    .den       (m2_den),
    .tag       (m2_tag),
    .out_valid (sd_valid),
    .quot      (sq),
    .over      (s_over),
    .out_tag   (sd_tag)
  );

  // Final result: move the weight against the sign of the first moment by the step, and clamp.
  logic               f_msign, f_mzero, f_dz;
  logic signed [31:0] f_w;
  logic [33:0]        step;
  logic signed [35:0] r_sum;
  out_t               f_res;

  assign f_msign = sd_tag[34];
  assign f_mzero = sd_tag[33];
  assign f_w     = sd_tag[32:1];
  assign f_dz    = sd_tag[0];
  assign step    = (s_over || (sq > STEP_CAP)) ? STEP_CAP : sq;
  assign r_sum   = f_msign ? ($signed(36'(f_w)) + $signed({2'b00, step}))
                           : ($signed(36'(f_w)) - $signed({2'b00, step}));

  always_comb begin
    if (f_dz) begin
      f_res.saturated  = 1'b1;
      f_res.weight_out = f_mzero ? f_w : (f_msign ? W_MAX : W_MIN);
    end else if (r_sum > 36'(W_MAX)) begin
      f_res.saturated  = 1'b1;
      f_res.weight_out = W_MAX;
    end else if (r_sum < 36'(W_MIN)) begin
      f_res.saturated  = 1'b1;
      f_res.weight_out = W_MIN;
    end else begin
      f_res.saturated  = 1'b0;
      f_res.weight_out = r_sum[31:0];
    end
  end

  // Output register plus one skid entry.
  logic f_arrive;
  logic take;
  out_t skid;

  assign f_arrive = en && sd_valid;
  assign take     = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= f_arrive;
      end
    end else if (f_arrive) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      out_data <= skid_valid ? skid : f_res;
    end else if (f_arrive) begin
      skid <= f_res;
    end
  end

endmodule
